[hdl/format_specifier_parser_core_defines.svh]
// ----------------------------------------------------------------------------
// format specifier parser - assertion macros
// Shared property macros for the checker of the format specifier parser.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPECIFIER_PARSER_CORE_DEFINES_SVH
`define FORMAT_SPECIFIER_PARSER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsp checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsp checker: next-cycle property failed");

`endif

[hdl/fsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg - format specifier parser package
// Character codes, result codes, result record and digit arithmetic.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // widths
  localparam int CHAR_BITS       = 8;
  localparam int NUMBER_BITS     = 16;
  localparam int OUT_NUMBER_BITS = 16;
  localparam int COUNT_BITS      = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS  = PTR_BITS + 1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_SPEC    = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_NUL     = CHAR_BITS'(8'h00);
  localparam logic [CHAR_BITS-1:0] CH_PERCENT = CHAR_BITS'(8'h25);
  localparam logic [CHAR_BITS-1:0] CH_MINUS   = CHAR_BITS'(8'h2D);
  localparam logic [CHAR_BITS-1:0] CH_PLUS    = CHAR_BITS'(8'h2B);
  localparam logic [CHAR_BITS-1:0] CH_HASH    = CHAR_BITS'(8'h23);
  localparam logic [CHAR_BITS-1:0] CH_ZERO    = CHAR_BITS'(8'h30);
  localparam logic [CHAR_BITS-1:0] CH_ONE     = CHAR_BITS'(8'h31);
  localparam logic [CHAR_BITS-1:0] CH_NINE    = CHAR_BITS'(8'h39);
  localparam logic [CHAR_BITS-1:0] CH_STAR    = CHAR_BITS'(8'h2A);
  localparam logic [CHAR_BITS-1:0] CH_DOT     = CHAR_BITS'(8'h2E);
  localparam logic [CHAR_BITS-1:0] CH_LC_H    = CHAR_BITS'(8'h68);
  localparam logic [CHAR_BITS-1:0] CH_LC_L    = CHAR_BITS'(8'h6C);
  localparam logic [CHAR_BITS-1:0] CH_LC_J    = CHAR_BITS'(8'h6A);
  localparam logic [CHAR_BITS-1:0] CH_LC_Z    = CHAR_BITS'(8'h7A);
  localparam logic [CHAR_BITS-1:0] CH_LC_T    = CHAR_BITS'(8'h74);
  localparam logic [CHAR_BITS-1:0] CH_UC_L    = CHAR_BITS'(8'h4C);
  localparam logic [CHAR_BITS-1:0] CH_LC_C    = CHAR_BITS'(8'h63);
  localparam logic [CHAR_BITS-1:0] CH_LC_S    = CHAR_BITS'(8'h73);
  localparam logic [CHAR_BITS-1:0] CH_UC_S    = CHAR_BITS'(8'h53);
  localparam logic [CHAR_BITS-1:0] CH_LC_D    = CHAR_BITS'(8'h64);
  localparam logic [CHAR_BITS-1:0] CH_LC_I    = CHAR_BITS'(8'h69);
  localparam logic [CHAR_BITS-1:0] CH_LC_X    = CHAR_BITS'(8'h78);
  localparam logic [CHAR_BITS-1:0] CH_UC_X    = CHAR_BITS'(8'h58);
  localparam logic [CHAR_BITS-1:0] CH_LC_U    = CHAR_BITS'(8'h75);
  localparam logic [CHAR_BITS-1:0] CH_LC_F    = CHAR_BITS'(8'h66);
  localparam logic [CHAR_BITS-1:0] CH_LC_P    = CHAR_BITS'(8'h70);

  // flag bit positions
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_SIGN  = 1;
  localparam int FLAG_ALT   = 2;
  localparam int FLAG_ZPAD  = 3;

  // length modifier codes
  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_HH   = 4'd1;
  localparam logic [3:0] LEN_H    = 4'd2;
  localparam logic [3:0] LEN_L    = 4'd3;
  localparam logic [3:0] LEN_LL   = 4'd4;
  localparam logic [3:0] LEN_J    = 4'd5;
  localparam logic [3:0] LEN_Z    = 4'd6;
  localparam logic [3:0] LEN_T    = 4'd7;
  localparam logic [3:0] LEN_LD   = 4'd8;

  // conversion codes
  localparam logic [3:0] CONV_PERCENT = 4'd0;
  localparam logic [3:0] CONV_CHAR    = 4'd1;
  localparam logic [3:0] CONV_STR     = 4'd2;
  localparam logic [3:0] CONV_WSTR    = 4'd3;
  localparam logic [3:0] CONV_INT     = 4'd4;
  localparam logic [3:0] CONV_HEX     = 4'd5;
  localparam logic [3:0] CONV_HEX_UC  = 4'd6;
  localparam logic [3:0] CONV_UINT    = 4'd7;
  localparam logic [3:0] CONV_FLOAT   = 4'd8;
  localparam logic [3:0] CONV_PTR     = 4'd9;

  // one result item
  typedef struct packed {
    kind_t                      kind;
    logic [COUNT_BITS-1:0]      consumed;
    logic [3:0]                 flags_mask;
    logic [OUT_NUMBER_BITS-1:0] min_width;
    logic                       width_from_arg;
    logic                       precision_given;
    logic [OUT_NUMBER_BITS-1:0] precision_value;
    logic                       precision_from_arg;
    logic [3:0]                 length_modifier;
    logic [3:0]                 conversion;
    logic                       last_result;
  } result_t;

  // conversion lookup: valid bit above the code
  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } conv_t;

  function automatic conv_t conv_lookup(input logic [CHAR_BITS-1:0] c);
    conv_t r;
    r.valid = 1'b1;
    unique case (c)
      CH_PERCENT: r.code = CONV_PERCENT;
      CH_LC_C:    r.code = CONV_CHAR;
      CH_LC_S:    r.code = CONV_STR;
      CH_UC_S:    r.code = CONV_WSTR;
      CH_LC_D:    r.code = CONV_INT;
      CH_LC_I:    r.code = CONV_INT;
      CH_LC_X:    r.code = CONV_HEX;
      CH_UC_X:    r.code = CONV_HEX_UC;
      CH_LC_U:    r.code = CONV_UINT;
      CH_LC_F:    r.code = CONV_FLOAT;
      CH_LC_P:    r.code = CONV_PTR;
      default: begin
        r.valid = 1'b0;
        r.code  = CONV_PERCENT;
      end
    endcase
    return r;
  endfunction

  // acc * 10 + d, saturating at the all-ones value
  function automatic logic [NUMBER_BITS-1:0] add_digit(input logic [NUMBER_BITS-1:0] acc,
                                                       input logic [3:0] d);
    logic [NUMBER_BITS+3:0] v;
    v = (NUMBER_BITS+4)'({acc, 3'b000}) + (NUMBER_BITS+4)'({acc, 1'b0})
      + (NUMBER_BITS+4)'(d);
    if (v > (NUMBER_BITS+4)'({NUMBER_BITS{1'b1}})) begin
      return {NUMBER_BITS{1'b1}};
    end
    return v[NUMBER_BITS-1:0];
  endfunction

endpackage

[hdl/format_specifier_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_specifier_parser_core - printf-style format specifier parser
// Results are written into the output queue and offered on the out_ port from its head.
// Throughput: one character per cycle while in_stall is low; parse state updates in a single step.
// An item may give two results; in_stall rises while the four-entry output
// queue has fewer than two free slots, so the drain rate of out_ sets the pace.
// Reset (synchronous, rst_n low) returns to idle and empties the queue.
// ----------------------------------------------------------------------------
module format_specifier_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_consumed,
  output logic [3:0]  out_flags_mask,
  output logic [15:0] out_min_width,
  output logic        out_width_from_arg,
  output logic        out_precision_given,
  output logic [15:0] out_precision_value,
  output logic        out_precision_from_arg,
  output logic [3:0]  out_length_modifier,
  output logic [3:0]  out_conversion,
  output logic        out_last_result
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_FLAGS,
    PH_WDIG,
    PH_PREC,
    PH_PDOT,
    PH_PDIG,
    PH_LEN,
    PH_LEN_H,
    PH_LEN_L,
    PH_TYPE
  } phase_t;

  // parse state
  phase_t                              phase_r, phase_nxt;
  logic [3:0]                          flags_r, flags_nxt;
  logic [fsp_pkg::NUMBER_BITS-1:0]     wacc_r, wacc_nxt;
  logic                                wstar_r, wstar_nxt;
  logic                                dot_r, dot_nxt;
  logic [fsp_pkg::NUMBER_BITS-1:0]     pacc_r, pacc_nxt;
  logic                                pstar_r, pstar_nxt;
  logic [3:0]                          len_r, len_nxt;
  logic [fsp_pkg::COUNT_BITS-1:0]      cnt_r, cnt_nxt;

  // output queue
  fsp_pkg::result_t                    queue_r [fsp_pkg::QUEUE_DEPTH];
  logic [fsp_pkg::PTR_BITS-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [fsp_pkg::PTR_BITS-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [fsp_pkg::PTR_BITS-1:0]        wr_ptr_second;
  logic [fsp_pkg::LEVEL_BITS-1:0]      level_r, level_nxt;

  // per-item decode
  logic [fsp_pkg::CHAR_BITS-1:0]       ch;
  logic                                ch_nul;
  logic                                ch_digit;
  logic                                ch_nz_digit;
  logic [3:0]                          ch_val;
  fsp_pkg::conv_t                      conv;
  logic [fsp_pkg::COUNT_BITS-1:0]      cnt_bump;
  logic                                reach_prec;
  logic                                reach_len;
  logic                                reach_type;
  logic                                taken;
  logic                                spec_done;
  logic                                spec_err;
  fsp_pkg::result_t                    idle_res;
  fsp_pkg::result_t                    res0, res1;
  logic [1:0]                          push_n;
  logic                                in_acc;
  logic                                out_pop;
  fsp_pkg::result_t                    head;

  assign in_acc  = in_valid && !in_stall;
  assign out_pop = out_valid && !out_stall;

  // character classes
  assign ch          = in_character;
  assign ch_nul      = (ch == fsp_pkg::CH_NUL);
  assign ch_digit    = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);
  assign ch_nz_digit = (ch >= fsp_pkg::CH_ONE) && (ch <= fsp_pkg::CH_NINE);
  assign ch_val      = 4'(ch - fsp_pkg::CH_ZERO);
  assign conv        = fsp_pkg::conv_lookup(ch);
  assign cnt_bump    = (cnt_r == fsp_pkg::COUNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // result for a character seen outside a specifier
  always_comb begin
    idle_res             = '0;
    idle_res.kind        = ch_nul ? fsp_pkg::KIND_END : fsp_pkg::KIND_LITERAL;
    idle_res.consumed    = ch_nul ? '0 : fsp_pkg::COUNT_BITS'(1);
    idle_res.last_result = 1'b1;
  end

  // specifier stepping, with fall-through from optional parts to later ones
  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    wacc_nxt   = wacc_r;
    wstar_nxt  = wstar_r;
    dot_nxt    = dot_r;
    pacc_nxt   = pacc_r;
    pstar_nxt  = pstar_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    reach_prec = 1'b0;
    reach_len  = 1'b0;
    reach_type = 1'b0;
    taken      = 1'b0;
    spec_done  = 1'b0;
    spec_err   = 1'b0;
    res0       = '0;
    res1       = '0;
    push_n     = 2'd0;

    if (phase_r != PH_IDLE && ch_nul) begin
      spec_err = 1'b1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_FLAGS: begin
          priority if (ch == fsp_pkg::CH_MINUS) begin
            flags_nxt[fsp_pkg::FLAG_LEFT] = 1'b1;
            taken = 1'b1;
          end else if (ch == fsp_pkg::CH_PLUS) begin
            flags_nxt[fsp_pkg::FLAG_SIGN] = 1'b1;
            taken = 1'b1;
          end else if (ch == fsp_pkg::CH_HASH) begin
            flags_nxt[fsp_pkg::FLAG_ALT] = 1'b1;
            taken = 1'b1;
          end else if (ch == fsp_pkg::CH_ZERO) begin
            flags_nxt[fsp_pkg::FLAG_ZPAD] = 1'b1;
            taken = 1'b1;
          end else if (ch == fsp_pkg::CH_STAR) begin
            wstar_nxt = 1'b1;
            phase_nxt = PH_PREC;
            taken     = 1'b1;
          end else if (ch_nz_digit) begin
            wacc_nxt  = fsp_pkg::add_digit('0, ch_val);
            phase_nxt = PH_WDIG;
            taken     = 1'b1;
          end else begin
            reach_prec = 1'b1;
          end
        end
        PH_WDIG: begin
          if (ch_digit) begin
            wacc_nxt = fsp_pkg::add_digit(wacc_r, ch_val);
            taken    = 1'b1;
          end else begin
            reach_prec = 1'b1;
          end
        end
        PH_PREC: reach_prec = 1'b1;
        PH_PDOT: begin
          priority if (ch == fsp_pkg::CH_STAR) begin
            pstar_nxt = 1'b1;
            phase_nxt = PH_LEN;
            taken     = 1'b1;
          end else if (ch_nz_digit) begin
            pacc_nxt  = fsp_pkg::add_digit('0, ch_val);
            phase_nxt = PH_PDIG;
            taken     = 1'b1;
          end else begin
            reach_len = 1'b1;
          end
        end
        PH_PDIG: begin
          if (ch_digit) begin
            pacc_nxt = fsp_pkg::add_digit(pacc_r, ch_val);
            taken    = 1'b1;
          end else begin
            reach_len = 1'b1;
          end
        end
        PH_LEN: reach_len = 1'b1;
        PH_LEN_H: begin
          if (ch == fsp_pkg::CH_LC_H) begin
            len_nxt   = fsp_pkg::LEN_HH;
            phase_nxt = PH_TYPE;
            taken     = 1'b1;
          end else begin
            len_nxt    = fsp_pkg::LEN_H;
            reach_type = 1'b1;
          end
        end
        PH_LEN_L: begin
          if (ch == fsp_pkg::CH_LC_L) begin
            len_nxt   = fsp_pkg::LEN_LL;
            phase_nxt = PH_TYPE;
            taken     = 1'b1;
          end else begin
            len_nxt    = fsp_pkg::LEN_L;
            reach_type = 1'b1;
          end
        end
        PH_TYPE: reach_type = 1'b1;
        default: begin
        end
      endcase

      // precision dot
      if (reach_prec) begin
        if (ch == fsp_pkg::CH_DOT) begin
          dot_nxt   = 1'b1;
          phase_nxt = PH_PDOT;
          taken     = 1'b1;
        end else begin
          reach_len = 1'b1;
        end
      end

      // length modifier
      if (reach_len) begin
        priority if (ch == fsp_pkg::CH_LC_H) begin
          phase_nxt = PH_LEN_H;
          taken     = 1'b1;
        end else if (ch == fsp_pkg::CH_LC_L) begin
          phase_nxt = PH_LEN_L;
          taken     = 1'b1;
        end else if (ch == fsp_pkg::CH_LC_J) begin
          len_nxt   = fsp_pkg::LEN_J;
          phase_nxt = PH_TYPE;
          taken     = 1'b1;
        end else if (ch == fsp_pkg::CH_LC_Z) begin
          len_nxt   = fsp_pkg::LEN_Z;
          phase_nxt = PH_TYPE;
          taken     = 1'b1;
        end else if (ch == fsp_pkg::CH_LC_T) begin
          len_nxt   = fsp_pkg::LEN_T;
          phase_nxt = PH_TYPE;
          taken     = 1'b1;
        end else if (ch == fsp_pkg::CH_UC_L) begin
          len_nxt   = fsp_pkg::LEN_LD;
          phase_nxt = PH_TYPE;
          taken     = 1'b1;
        end else begin
          reach_type = 1'b1;
        end
      end

      // conversion character
      if (reach_type) begin
        if (conv.valid) begin
          spec_done = 1'b1;
        end else begin
          spec_err = 1'b1;
        end
      end
    end

    if (taken) begin
      cnt_nxt = cnt_bump;
    end

    // results
    if (spec_done) begin
      res0.kind               = fsp_pkg::KIND_SPEC;
      res0.consumed           = cnt_bump;
      res0.flags_mask         = flags_nxt;
      res0.min_width          = fsp_pkg::OUT_NUMBER_BITS'(wacc_nxt);
      res0.width_from_arg     = wstar_nxt;
      res0.precision_given    = dot_nxt;
      res0.precision_value    = fsp_pkg::OUT_NUMBER_BITS'(pacc_nxt);
      res0.precision_from_arg = pstar_nxt;
      res0.length_modifier    = len_nxt;
      res0.conversion         = conv.code;
      res0.last_result        = 1'b1;
      push_n                  = 2'd1;
    end else if (spec_err) begin
      res0.kind        = fsp_pkg::KIND_ERROR;
      res0.consumed    = cnt_r;
      res0.last_result = (ch == fsp_pkg::CH_PERCENT);
      res1             = idle_res;
      push_n           = (ch == fsp_pkg::CH_PERCENT) ? 2'd1 : 2'd2;
    end else if (phase_r == PH_IDLE) begin
      res0   = idle_res;
      push_n = (ch == fsp_pkg::CH_PERCENT) ? 2'd0 : 2'd1;
    end

    // close the specifier, and reopen on a '%' seen from idle
    if (spec_done || spec_err || phase_r == PH_IDLE) begin
      phase_nxt = PH_IDLE;
      flags_nxt = '0;
      wacc_nxt  = '0;
      wstar_nxt = 1'b0;
      dot_nxt   = 1'b0;
      pacc_nxt  = '0;
      pstar_nxt = 1'b0;
      len_nxt   = fsp_pkg::LEN_NONE;
      cnt_nxt   = '0;
      if (!spec_done && ch == fsp_pkg::CH_PERCENT) begin
        phase_nxt = PH_FLAGS;
        cnt_nxt   = fsp_pkg::COUNT_BITS'(1);
      end
    end
  end

  // queue pointers and fill level
  assign wr_ptr_second = fsp_pkg::PTR_BITS'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt    = in_acc ? fsp_pkg::PTR_BITS'(wr_ptr_r + push_n) : wr_ptr_r;
  assign rd_ptr_nxt    = out_pop ? fsp_pkg::PTR_BITS'(rd_ptr_r + 1'b1) : rd_ptr_r;
  assign level_nxt     = level_r
                       + (in_acc ? fsp_pkg::LEVEL_BITS'(push_n) : '0)
                       - fsp_pkg::LEVEL_BITS'(out_pop);

  assign in_stall = (level_r > fsp_pkg::LEVEL_BITS'(fsp_pkg::QUEUE_DEPTH - 2));

  // state, queue and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      flags_r  <= '0;
      wacc_r   <= '0;
      wstar_r  <= 1'b0;
      dot_r    <= 1'b0;
      pacc_r   <= '0;
      pstar_r  <= 1'b0;
      len_r    <= fsp_pkg::LEN_NONE;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        flags_r <= flags_nxt;
        wacc_r  <= wacc_nxt;
        wstar_r <= wstar_nxt;
        dot_r   <= dot_nxt;
        pacc_r  <= pacc_nxt;
        pstar_r <= pstar_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        if (push_n != 2'd0) begin
          queue_r[wr_ptr_r] <= res0;
        end
        if (push_n == 2'd2) begin
          queue_r[wr_ptr_second] <= res1;
        end
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // head of the queue drives the result channel
  assign head                   = queue_r[rd_ptr_r];
  assign out_valid              = (level_r != '0);
  assign out_kind               = head.kind;
  assign out_consumed           = head.consumed;
  assign out_flags_mask         = head.flags_mask;
  assign out_min_width          = head.min_width;
  assign out_width_from_arg     = head.width_from_arg;
  assign out_precision_given    = head.precision_given;
  assign out_precision_value    = head.precision_value;
  assign out_precision_from_arg = head.precision_from_arg;
  assign out_length_modifier    = head.length_modifier;
  assign out_conversion         = head.conversion;
  assign out_last_result        = head.last_result;

endmodule

[hdl/fsp_port_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_port_checker - port-level checks for the format specifier parser
// Watches the result channel and checks the shape of each result item.
// ----------------------------------------------------------------------------
`include "format_specifier_parser_core_defines.svh"

module fsp_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_consumed,
  input logic [3:0]  out_flags_mask,
  input logic [15:0] out_min_width,
  input logic        out_width_from_arg,
  input logic        out_precision_given,
  input logic [15:0] out_precision_value,
  input logic        out_precision_from_arg,
  input logic [3:0]  out_length_modifier,
  input logic [3:0]  out_conversion,
  input logic        out_last_result
);

  logic is_end;
  logic is_literal;
  logic is_spec;
  logic is_plain;
  logic end_ok;
  logic literal_ok;
  logic spec_ok;
  logic plain_ok;

  // kind of the offered result item
  assign is_end     = out_valid && (out_kind == fsp_pkg::KIND_END);
  assign is_literal = out_valid && (out_kind == fsp_pkg::KIND_LITERAL);
  assign is_spec    = out_valid && (out_kind == fsp_pkg::KIND_SPEC);
  assign is_plain   = out_valid && (out_kind != fsp_pkg::KIND_SPEC);

  // expected shape for each kind
  assign end_ok     = (out_consumed == 8'd0) && out_last_result;
  assign literal_ok = (out_consumed == 8'd1) && out_last_result;
  assign spec_ok    = (out_consumed >= 8'd2) && out_last_result
                   && (out_conversion <= fsp_pkg::CONV_PTR)
                   && (out_length_modifier <= fsp_pkg::LEN_LD);
  assign plain_ok   = (out_flags_mask == 4'd0) && (out_min_width == 16'd0)
                   && !out_width_from_arg && !out_precision_given
                   && (out_precision_value == 16'd0) && !out_precision_from_arg
                   && (out_length_modifier == 4'd0) && (out_conversion == 4'd0);

  // a stalled result item stays offered
  `FSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // end of string takes no characters and closes its item
  `FSP_ASSERT_SAME(a_end_shape, clk, rst_n, is_end, end_ok)

  // a literal takes exactly one character and closes its item
  `FSP_ASSERT_SAME(a_literal_shape, clk, rst_n, is_literal, literal_ok)

  // a specifier spans at least '%' and its type, with legal codes
  `FSP_ASSERT_SAME(a_spec_shape, clk, rst_n, is_spec, spec_ok)

  // only specifiers carry detail fields
  `FSP_ASSERT_SAME(a_plain_fields, clk, rst_n, is_plain, plain_ok)

endmodule

bind format_specifier_parser_core fsp_port_checker u_fsp_port_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - format specifier parser testbench
// Feeds directed and random character streams (well-formed specifiers, broken
// specifiers and noise) through the parser with random idling on both sides,
// and checks every result item against a built-in predictor of the parser.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_PCT  = 29;
  localparam int CALM_FROM = 300;
  localparam int CALM_TO   = 600;

  // parse phases of the predictor
  typedef enum logic [3:0] {
    ST_IDLE, ST_FLAGS, ST_WDIG, ST_PREC, ST_PDOT, ST_PDIG,
    ST_LEN, ST_LEN_H, ST_LEN_L, ST_TYPE
  } scan_state_t;

  // outcome of one character inside an open specifier
  typedef enum {FEED_MORE, FEED_DONE, FEED_BAD} feed_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_character = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_consumed;
  logic [3:0]  out_flags_mask;
  logic [15:0] out_min_width;
  logic        out_width_from_arg;
  logic        out_precision_given;
  logic [15:0] out_precision_value;
  logic        out_precision_from_arg;
  logic [3:0]  out_length_modifier;
  logic [3:0]  out_conversion;
  logic        out_last_result;

  format_specifier_parser_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_character           (in_character),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_kind               (out_kind),
    .out_consumed           (out_consumed),
    .out_flags_mask         (out_flags_mask),
    .out_min_width          (out_min_width),
    .out_width_from_arg     (out_width_from_arg),
    .out_precision_given    (out_precision_given),
    .out_precision_value    (out_precision_value),
    .out_precision_from_arg (out_precision_from_arg),
    .out_length_modifier    (out_length_modifier),
    .out_conversion         (out_conversion),
    .out_last_result        (out_last_result)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]        pending_chars[$];
  fsp_pkg::result_t  expected_results[$];
  int                taken_count = 0;
  int                queued_count = 0;
  int                mismatches = 0;

  logic [7:0] flag_chars[4] = '{fsp_pkg::CH_MINUS, fsp_pkg::CH_PLUS,
                                fsp_pkg::CH_HASH, fsp_pkg::CH_ZERO};
  logic [7:0] conv_chars[11] = '{fsp_pkg::CH_PERCENT, fsp_pkg::CH_LC_C, fsp_pkg::CH_LC_S,
                                 fsp_pkg::CH_UC_S, fsp_pkg::CH_LC_D, fsp_pkg::CH_LC_I,
                                 fsp_pkg::CH_LC_X, fsp_pkg::CH_UC_X, fsp_pkg::CH_LC_U,
                                 fsp_pkg::CH_LC_F, fsp_pkg::CH_LC_P};

  // predictor state for the specifier being parsed
  scan_state_t scan_state = ST_IDLE;
  logic [3:0]  spec_flags;
  logic [15:0] spec_width;
  logic        spec_width_star;
  logic        spec_dot;
  logic [15:0] spec_prec;
  logic        spec_prec_star;
  logic [3:0]  spec_len;
  logic [7:0]  spec_count;
  logic [3:0]  spec_conv;

  function automatic void clear_spec();
    spec_flags      = '0;
    spec_width      = '0;
    spec_width_star = 1'b0;
    spec_dot        = 1'b0;
    spec_prec       = '0;
    spec_prec_star  = 1'b0;
    spec_len        = fsp_pkg::LEN_NONE;
    spec_count      = '0;
    spec_conv       = fsp_pkg::CONV_PERCENT;
  endfunction

  function automatic void bump_count();
    if (spec_count != 8'hFF) spec_count = spec_count + 8'd1;
  endfunction

  // character taken inside a specifier, parsing moves on to nxt
  function automatic feed_t took(input scan_state_t nxt);
    bump_count();
    scan_state = nxt;
    return FEED_MORE;
  endfunction

  function automatic logic dec_char(input logic [7:0] c);
    return c >= fsp_pkg::CH_ZERO && c <= fsp_pkg::CH_NINE;
  endfunction

  function automatic logic nz_dec_char(input logic [7:0] c);
    return c >= fsp_pkg::CH_ONE && c <= fsp_pkg::CH_NINE;
  endfunction

  // decimal accumulate, pinned at the all-ones value
  function automatic logic [15:0] append_digit(input logic [15:0] acc, input logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - fsp_pkg::CH_ZERO);
    return (v > 32'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic conv_of(input logic [7:0] c, output logic [3:0] code);
    code = fsp_pkg::CONV_PERCENT;
    case (c)
      fsp_pkg::CH_PERCENT: code = fsp_pkg::CONV_PERCENT;
      fsp_pkg::CH_LC_C:    code = fsp_pkg::CONV_CHAR;
      fsp_pkg::CH_LC_S:    code = fsp_pkg::CONV_STR;
      fsp_pkg::CH_UC_S:    code = fsp_pkg::CONV_WSTR;
      fsp_pkg::CH_LC_D, fsp_pkg::CH_LC_I: code = fsp_pkg::CONV_INT;
      fsp_pkg::CH_LC_X:    code = fsp_pkg::CONV_HEX;
      fsp_pkg::CH_UC_X:    code = fsp_pkg::CONV_HEX_UC;
      fsp_pkg::CH_LC_U:    code = fsp_pkg::CONV_UINT;
      fsp_pkg::CH_LC_F:    code = fsp_pkg::CONV_FLOAT;
      fsp_pkg::CH_LC_P:    code = fsp_pkg::CONV_PTR;
      default:             return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // one character into an open specifier; fields not matched fall through
  function automatic feed_t feed_spec(input logic [7:0] c);
    scan_state_t st;
    logic [3:0]  code;
    st = scan_state;
    if (c == fsp_pkg::CH_NUL) return FEED_BAD;
    repeat (10) begin
      case (st)
        ST_FLAGS: begin
          if (c == fsp_pkg::CH_MINUS) begin
            spec_flags[fsp_pkg::FLAG_LEFT] = 1'b1;
            return took(ST_FLAGS);
          end
          if (c == fsp_pkg::CH_PLUS) begin
            spec_flags[fsp_pkg::FLAG_SIGN] = 1'b1;
            return took(ST_FLAGS);
          end
          if (c == fsp_pkg::CH_HASH) begin
            spec_flags[fsp_pkg::FLAG_ALT] = 1'b1;
            return took(ST_FLAGS);
          end
          if (c == fsp_pkg::CH_ZERO) begin
            spec_flags[fsp_pkg::FLAG_ZPAD] = 1'b1;
            return took(ST_FLAGS);
          end
          if (c == fsp_pkg::CH_STAR) begin
            spec_width_star = 1'b1;
            return took(ST_PREC);
          end
          if (nz_dec_char(c)) begin
            spec_width = append_digit('0, c);
            return took(ST_WDIG);
          end
          st = ST_PREC;
        end
        ST_WDIG: begin
          if (dec_char(c)) begin
            spec_width = append_digit(spec_width, c);
            return took(ST_WDIG);
          end
          st = ST_PREC;
        end
        ST_PREC: begin
          if (c == fsp_pkg::CH_DOT) begin
            spec_dot = 1'b1;
            return took(ST_PDOT);
          end
          st = ST_LEN;
        end
        ST_PDOT: begin
          if (c == fsp_pkg::CH_STAR) begin
            spec_prec_star = 1'b1;
            return took(ST_LEN);
          end
          if (nz_dec_char(c)) begin
            spec_prec = append_digit('0, c);
            return took(ST_PDIG);
          end
          st = ST_LEN;
        end
        ST_PDIG: begin
          if (dec_char(c)) begin
            spec_prec = append_digit(spec_prec, c);
            return took(ST_PDIG);
          end
          st = ST_LEN;
        end
        ST_LEN: begin
          if (c == fsp_pkg::CH_LC_H) return took(ST_LEN_H);
          if (c == fsp_pkg::CH_LC_L) return took(ST_LEN_L);
          if (c == fsp_pkg::CH_LC_J) begin
            spec_len = fsp_pkg::LEN_J;
            return took(ST_TYPE);
          end
          if (c == fsp_pkg::CH_LC_Z) begin
            spec_len = fsp_pkg::LEN_Z;
            return took(ST_TYPE);
          end
          if (c == fsp_pkg::CH_LC_T) begin
            spec_len = fsp_pkg::LEN_T;
            return took(ST_TYPE);
          end
          if (c == fsp_pkg::CH_UC_L) begin
            spec_len = fsp_pkg::LEN_LD;
            return took(ST_TYPE);
          end
          st = ST_TYPE;
        end
        ST_LEN_H: begin
          if (c == fsp_pkg::CH_LC_H) begin
            spec_len = fsp_pkg::LEN_HH;
            return took(ST_TYPE);
          end
          spec_len = fsp_pkg::LEN_H;
          st = ST_TYPE;
        end
        ST_LEN_L: begin
          if (c == fsp_pkg::CH_LC_L) begin
            spec_len = fsp_pkg::LEN_LL;
            return took(ST_TYPE);
          end
          spec_len = fsp_pkg::LEN_L;
          st = ST_TYPE;
        end
        default: begin
          if (!conv_of(c, code)) return FEED_BAD;
          spec_conv = code;
          bump_count();
          return FEED_DONE;
        end
      endcase
    end
    return FEED_BAD;
  endfunction

  function automatic void push_plain(input fsp_pkg::kind_t k, input logic [7:0] n);
    fsp_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.consumed = n;
    expected_results.push_back(r);
  endfunction

  // character seen outside a specifier
  function automatic void start_from_idle(input logic [7:0] c);
    if (c == fsp_pkg::CH_NUL) begin
      push_plain(fsp_pkg::KIND_END, 8'd0);
    end else if (c != fsp_pkg::CH_PERCENT) begin
      push_plain(fsp_pkg::KIND_LITERAL, 8'd1);
    end else begin
      clear_spec();
      spec_count = 8'd1;
      scan_state = ST_FLAGS;
    end
  endfunction

  // expected result items for one accepted character
  function automatic void predict_char(input logic [7:0] c);
    fsp_pkg::result_t r;
    int               before_cnt;
    feed_t            f;
    before_cnt = expected_results.size();
    if (scan_state == ST_IDLE) begin
      start_from_idle(c);
    end else begin
      f = feed_spec(c);
      if (f == FEED_DONE) begin
        r = '0;
        r.kind               = fsp_pkg::KIND_SPEC;
        r.consumed           = spec_count;
        r.flags_mask         = spec_flags;
        r.min_width          = spec_width;
        r.width_from_arg     = spec_width_star;
        r.precision_given    = spec_dot;
        r.precision_value    = spec_prec;
        r.precision_from_arg = spec_prec_star;
        r.length_modifier    = spec_len;
        r.conversion         = spec_conv;
        expected_results.push_back(r);
        clear_spec();
        scan_state = ST_IDLE;
      end else if (f == FEED_BAD) begin
        push_plain(fsp_pkg::KIND_ERROR, spec_count);
        clear_spec();
        scan_state = ST_IDLE;
        start_from_idle(c);
      end
    end
    // mark the final item of this character
    if (expected_results.size() > before_cnt) begin
      r = expected_results.pop_back();
      r.last_result = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  // random idling, with a calm stretch in the middle of the run
  function automatic logic idle_roll();
    if (taken_count >= CALM_FROM && taken_count < CALM_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_character <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_char(in_character);
        taken_count <= taken_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() != 0 && !idle_roll()) begin
          in_valid     <= 1'b1;
          in_character <= pending_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    fsp_pkg::result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_roll();
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: kind %0d consumed %0d", out_kind, out_consumed);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("consumed", want.consumed, out_consumed);
          check_field("flags_mask", want.flags_mask, out_flags_mask);
          check_field("min_width", want.min_width, out_min_width);
          check_field("width_from_arg", want.width_from_arg, out_width_from_arg);
          check_field("precision_given", want.precision_given, out_precision_given);
          check_field("precision_value", want.precision_value, out_precision_value);
          check_field("precision_from_arg", want.precision_from_arg, out_precision_from_arg);
          check_field("length_modifier", want.length_modifier, out_length_modifier);
          check_field("conversion", want.conversion, out_conversion);
          check_field("last_result", want.last_result, out_last_result);
        end
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    pending_chars.push_back(c);
    queued_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_number(input int digits);
    push_char(fsp_pkg::CH_ONE + 8'($urandom_range(0, 8)));
    repeat (digits - 1) push_char(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // one specifier with random content; broken ones get a bad byte or an early nul
  task automatic gen_spec(input bit broken);
    logic [7:0] s[$];
    int         cut;
    s.push_back(fsp_pkg::CH_PERCENT);
    repeat ($urandom_range(0, 3)) s.push_back(flag_chars[$urandom_range(0, 3)]);
    case ($urandom_range(0, 7))
      3: s.push_back(fsp_pkg::CH_STAR);
      4, 5, 6: begin
        s.push_back(fsp_pkg::CH_ONE + 8'($urandom_range(0, 8)));
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(4, 6) : $urandom_range(0, 2))
          s.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      7: begin
        s.push_back(fsp_pkg::CH_STAR);
        s.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      default: ;
    endcase
    case ($urandom_range(0, 7))
      3: s.push_back(fsp_pkg::CH_DOT);
      4: begin
        s.push_back(fsp_pkg::CH_DOT);
        s.push_back(fsp_pkg::CH_STAR);
      end
      5, 6: begin
        s.push_back(fsp_pkg::CH_DOT);
        s.push_back(fsp_pkg::CH_ONE + 8'($urandom_range(0, 8)));
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(4, 6) : $urandom_range(0, 2))
          s.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      7: begin
        s.push_back(fsp_pkg::CH_DOT);
        s.push_back(fsp_pkg::CH_ZERO);
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      2: begin
        s.push_back(fsp_pkg::CH_LC_H);
        s.push_back(fsp_pkg::CH_LC_H);
      end
      3: s.push_back(fsp_pkg::CH_LC_H);
      4: s.push_back(fsp_pkg::CH_LC_L);
      5: begin
        s.push_back(fsp_pkg::CH_LC_L);
        s.push_back(fsp_pkg::CH_LC_L);
      end
      6: s.push_back(fsp_pkg::CH_LC_J);
      7: s.push_back(fsp_pkg::CH_LC_Z);
      8: s.push_back(fsp_pkg::CH_LC_T);
      9: s.push_back(fsp_pkg::CH_UC_L);
      default: ;
    endcase
    s.push_back(conv_chars[$urandom_range(0, 10)]);
    if (broken) begin
      cut = $urandom_range(1, s.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        s[cut] = 8'($urandom_range(0, 255));
      end else begin
        while (s.size() > cut) void'(s.pop_back());
        s.push_back(fsp_pkg::CH_NUL);
      end
    end
    foreach (s[i]) push_char(s[i]);
  endtask

  // mostly well-formed specifiers, the rest broken ones, raw bytes and nuls
  task automatic fill_random(input int n);
    int start_cnt;
    int roll;
    start_cnt = queued_count;
    while (queued_count - start_cnt < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) gen_spec(1'b0);
      else if (roll < 75) gen_spec(1'b1);
      else if (roll < 95) repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
      else push_char(fsp_pkg::CH_NUL);
    end
  endtask

  // wait until the sender is empty and every expected item has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // a plain literal, a literal at the top of the range, end of string
    push_text("A");
    push_char(8'hFF);
    push_char(fsp_pkg::CH_NUL);
    // percent escape, dot then zero, digit after width star, bad conversion
    push_text("%%%.0d%*5d%q");
    // every flag with both stars and a long double
    push_text("%-+#0*.*Lf");
    // nul inside a specifier
    push_char(fsp_pkg::CH_PERCENT);
    push_char(fsp_pkg::CH_NUL);
    wait_drained();

    fill_random(400);
    wait_drained();

    // count, width and precision all saturate
    push_char(fsp_pkg::CH_PERCENT);
    repeat (300) push_char(flag_chars[$urandom_range(0, 3)]);
    push_number(8);
    push_char(fsp_pkg::CH_DOT);
    push_number(8);
    push_text("lld");
    fill_random(400);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/fsp_pkg.sv
hdl/format_specifier_parser_core.sv
hdl/fsp_port_checker.sv
test/tb_top.sv
